[rtl/core/pure_nash_equilibrium_finder_defines.svh]
// Assertion macros used by the checker file of the equilibrium finder.
`ifndef PURE_NASH_EQUILIBRIUM_FINDER_DEFINES_SVH
`define PURE_NASH_EQUILIBRIUM_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PNEF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pnef assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PNEF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pnef assertion failed");

`endif

[rtl/core/pnef_pkg.sv]
// Shared types and constants of the pure Nash equilibrium finder.
package pnef_pkg;

  // Default game size
  localparam int DEF_MAX_ROWS = 8;
  localparam int DEF_MAX_COLS = 8;

  // Fixed field widths
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 4;
  localparam int PAY_W   = 16;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register indexes
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // Raw register contents handed to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] row_count;
    logic [CNT_W-1:0] col_count;
  } search_cfg_t;

endpackage

[rtl/core/pure_nash_equilibrium_finder.sv]
// Pure Nash equilibrium finder: loads payoff cells, searches with one shared comparator.
// Load transaction: item_ready stays high, so loads go back to back.
// Search transaction: the single comparator reads one payoff per cycle from the tables;
//   the walk stalls while a result waits and the result channel is not open.
// Results stream as found; one cell is held back so the final result carries last_of_run.
// Synchronous active-high reset clears sequencer, result valid, counts (to 8); not tables.
module pure_nash_equilibrium_finder #(
  parameter int MAX_ROWS = pnef_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = pnef_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              opcode,
  input  logic [pnef_pkg::IDX_W-1:0]        cell_row,
  input  logic [pnef_pkg::IDX_W-1:0]        cell_col,
  input  logic signed [pnef_pkg::PAY_W-1:0] payoff_row_player,
  input  logic signed [pnef_pkg::PAY_W-1:0] payoff_col_player,
  // results
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [pnef_pkg::IDX_W-1:0]        eq_row,
  output logic [pnef_pkg::IDX_W-1:0]        eq_col,
  output logic                              found,
  output logic                              last_of_run,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pnef_pkg::ADDR_W-1:0]       paddr,
  input  logic [pnef_pkg::DATA_W-1:0]       pwdata,
  output logic [pnef_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);
  import pnef_pkg::*;

  localparam int CELL_AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  search_cfg_t             cfg;
  logic                    busy;
  logic                    item_acc;
  logic [CELL_AW-1:0]      rd_addr_a, rd_addr_b;
  logic signed [PAY_W-1:0] rd_a, rd_b;

  assign item_ready = !busy;
  assign item_acc   = item_valid && item_ready;

  pnef_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pnef_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .CELL_AW  (CELL_AW)
  ) u_store (
    .clk               (clk),
    .load_en           (item_acc && (opcode == OP_LOAD)),
    .cell_row          (cell_row),
    .cell_col          (cell_col),
    .payoff_row_player (payoff_row_player),
    .payoff_col_player (payoff_col_player),
    .rd_addr_a         (rd_addr_a),
    .rd_addr_b         (rd_addr_b),
    .rd_a              (rd_a),
    .rd_b              (rd_b)
  );

  pnef_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .CELL_AW  (CELL_AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (item_acc && (opcode == OP_SEARCH)),
    .cfg          (cfg),
    .busy         (busy),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_a         (rd_a),
    .rd_b         (rd_b),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .eq_row       (eq_row),
    .eq_col       (eq_col),
    .found        (found),
    .last_of_run  (last_of_run)
  );

endmodule

[rtl/core/pnef_regs.sv]
// APB-style register block holding the row and column counts.
module pnef_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pnef_pkg::ADDR_W-1:0] paddr,
  input  logic [pnef_pkg::DATA_W-1:0] pwdata,
  output logic [pnef_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output pnef_pkg::search_cfg_t       cfg
);
  import pnef_pkg::*;

  logic             reg_idx;
  logic             wr_en;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CNT_W'(8);
      col_count <= CNT_W'(8);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROW_COUNT: row_count <= pwdata[CNT_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ROW_COUNT: prdata = DATA_W'(row_count);
      REG_COL_COUNT: prdata = DATA_W'(col_count);
      default: prdata = '0;
    endcase
  end

  assign cfg.row_count = row_count;
  assign cfg.col_count = col_count;

endmodule

[rtl/core/pnef_store.sv]
// Payoff tables A and B: one write port for loads, one read port each.
module pnef_store #(
  parameter int MAX_ROWS = pnef_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = pnef_pkg::DEF_MAX_COLS,
  parameter int CELL_AW  = 6
) (
  input  logic                              clk,
  input  logic                              load_en,
  input  logic [pnef_pkg::IDX_W-1:0]        cell_row,
  input  logic [pnef_pkg::IDX_W-1:0]        cell_col,
  input  logic signed [pnef_pkg::PAY_W-1:0] payoff_row_player,
  input  logic signed [pnef_pkg::PAY_W-1:0] payoff_col_player,
  input  logic [CELL_AW-1:0]                rd_addr_a,
  input  logic [CELL_AW-1:0]                rd_addr_b,
  output logic signed [pnef_pkg::PAY_W-1:0] rd_a,
  output logic signed [pnef_pkg::PAY_W-1:0] rd_b
);
  import pnef_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  logic signed [PAY_W-1:0] mem_a [DEPTH];
  logic signed [PAY_W-1:0] mem_b [DEPTH];
  logic                    in_range;
  logic                    wr_en;
  logic [CELL_AW-1:0]      wr_addr;

  // Loads outside the table are dropped
  assign in_range = ({1'b0, cell_row} < (IDX_W+1)'(MAX_ROWS)) &&
                    ({1'b0, cell_col} < (IDX_W+1)'(MAX_COLS));
  assign wr_en    = load_en && in_range;
  assign wr_addr  = CELL_AW'(cell_row) * CELL_AW'(MAX_COLS) + CELL_AW'(cell_col);

  // Table A
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= payoff_row_player;
    end
    rd_a <= mem_a[rd_addr_a];
  end

  // Table B
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_b[wr_addr] <= payoff_col_player;
    end
    rd_b <= mem_b[rd_addr_b];
  end

endmodule

[rtl/core/pnef_seq.sv]
// Search sequencer: walks cells, drives one shared signed comparator, queues results.
module pnef_seq #(
  parameter int MAX_ROWS = pnef_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = pnef_pkg::DEF_MAX_COLS,
  parameter int CELL_AW  = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  pnef_pkg::search_cfg_t             cfg,
  output logic                              busy,
  output logic [CELL_AW-1:0]                rd_addr_a,
  output logic [CELL_AW-1:0]                rd_addr_b,
  input  logic signed [pnef_pkg::PAY_W-1:0] rd_a,
  input  logic signed [pnef_pkg::PAY_W-1:0] rd_b,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [pnef_pkg::IDX_W-1:0]        eq_row,
  output logic [pnef_pkg::IDX_W-1:0]        eq_col,
  output logic                              found,
  output logic                              last_of_run
);
  import pnef_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REF  = 3'd1;
  localparam logic [2:0] S_LAT  = 3'd2;
  localparam logic [2:0] S_SA   = 3'd3;
  localparam logic [2:0] S_SB   = 3'd4;
  localparam logic [2:0] S_SW   = 3'd5;
  localparam logic [2:0] S_SD   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]              state;
  logic [IDX_W-1:0]        r, c, k;
  logic [CNT_W-1:0]        nr, nc;
  logic signed [PAY_W-1:0] ua, ub;
  logic                    fail;
  logic                    pend, pend_b;
  logic                    has_held;
  logic [IDX_W-1:0]        held_r, held_c;

  logic [CNT_W-1:0]        nr_next, nc_next;
  logic signed [PAY_W-1:0] cmp_op, cmp_ref;
  logic                    beat;
  logic                    out_free;
  logic                    k_last_a, k_last_b;
  logic                    c_last, r_last;
  logic [CELL_AW-1:0]      self_addr;

  assign busy = (state != S_IDLE);

  // Counts clamped to 1..MAX at search start
  always_comb begin
    if (cfg.row_count == '0) nr_next = CNT_W'(1);
    else if (cfg.row_count > CNT_W'(MAX_ROWS)) nr_next = CNT_W'(MAX_ROWS);
    else nr_next = cfg.row_count;
    if (cfg.col_count == '0) nc_next = CNT_W'(1);
    else if (cfg.col_count > CNT_W'(MAX_COLS)) nc_next = CNT_W'(MAX_COLS);
    else nc_next = cfg.col_count;
  end

  // Read addresses: column walk on A, row walk on B, else the cell itself
  assign self_addr = CELL_AW'(r) * CELL_AW'(MAX_COLS) + CELL_AW'(c);
  assign rd_addr_a = (state == S_SA) ?
                     CELL_AW'(k) * CELL_AW'(MAX_COLS) + CELL_AW'(c) : self_addr;
  assign rd_addr_b = (state == S_SB) ?
                     CELL_AW'(r) * CELL_AW'(MAX_COLS) + CELL_AW'(k) : self_addr;

  // Shared comparator on the registered read data of the tables
  assign cmp_op  = pend_b ? rd_b : rd_a;
  assign cmp_ref = pend_b ? ub : ua;
  assign beat    = pend && (cmp_op > cmp_ref);

  assign k_last_a = ({1'b0, k} == nr - CNT_W'(1));
  assign k_last_b = ({1'b0, k} == nc - CNT_W'(1));
  assign c_last   = ({1'b0, c} == nc - CNT_W'(1));
  assign r_last   = ({1'b0, r} == nr - CNT_W'(1));
  assign out_free = !result_valid || result_ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend     <= 1'b0;
      has_held <= 1'b0;
    end else begin
      if (beat) begin
        fail <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (start) begin
            nr    <= nr_next;
            nc    <= nc_next;
            r     <= '0;
            c     <= '0;
            state <= S_REF;
          end
        end
        S_REF: begin
          pend  <= 1'b0;
          fail  <= 1'b0;
          state <= S_LAT;
        end
        S_LAT: begin
          pend  <= 1'b0;
          ua    <= rd_a;
          ub    <= rd_b;
          k     <= '0;
          state <= S_SA;
        end
        S_SA: begin
          pend   <= 1'b1;
          pend_b <= 1'b0;
          if (k_last_a) begin
            k     <= '0;
            state <= S_SB;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_SB: begin
          pend   <= 1'b1;
          pend_b <= 1'b1;
          if (k_last_b) begin
            state <= S_SW;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_SW: begin
          pend  <= 1'b0;
          state <= S_SD;
        end
        S_SD: begin
          pend <= 1'b0;
          // Hold one equilibrium back so the final one can carry the last marker
          if (fail || !has_held || out_free) begin
            if (!fail) begin
              has_held <= 1'b1;
              held_r   <= r;
              held_c   <= c;
            end
            if (c_last) begin
              c <= '0;
              if (r_last) begin
                state <= S_FIN;
              end else begin
                r     <= r + IDX_W'(1);
                state <= S_REF;
              end
            end else begin
              c     <= c + IDX_W'(1);
              state <= S_REF;
            end
          end
        end
        S_FIN: begin
          pend <= 1'b0;
          if (out_free) begin
            has_held <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          pend  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_SD && !fail && has_held && out_free) begin
      result_valid <= 1'b1;
    end else if (state == S_FIN && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SD && !fail && has_held && out_free) begin
      eq_row      <= held_r;
      eq_col      <= held_c;
      found       <= 1'b1;
      last_of_run <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      eq_row      <= has_held ? held_r : '0;
      eq_col      <= has_held ? held_c : '0;
      found       <= has_held;
      last_of_run <= 1'b1;
    end
  end

endmodule

[rtl/core/pnef_checker.sv]
// Port-level checker for the equilibrium finder, bound to the top level.
`include "pure_nash_equilibrium_finder_defines.svh"

module pnef_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic                       opcode,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [pnef_pkg::IDX_W-1:0] eq_row,
  input logic [pnef_pkg::IDX_W-1:0] eq_col,
  input logic                       found,
  input logic                       last_of_run
);
  import pnef_pkg::*;

  // A stalled result holds its payload
  `PNEF_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(eq_row) && $stable(eq_col) && $stable(found) && $stable(last_of_run))

  // A not-found result is the single, final, zeroed result of its search
  `PNEF_ASSERT_IMP(a_notfound_last, result_valid && !found, last_of_run && eq_row == '0 && eq_col == '0)

  // A search holds off new items
  `PNEF_ASSERT_NXT(a_search_busy, item_valid && item_ready && opcode == OP_SEARCH, !item_ready)

  // A load leaves the block ready for the next item
  `PNEF_ASSERT_NXT(a_load_ready, item_valid && item_ready && opcode == OP_LOAD, item_ready)

endmodule

bind pure_nash_equilibrium_finder pnef_checker u_pnef_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .opcode       (opcode),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .eq_row       (eq_row),
  .eq_col       (eq_col),
  .found        (found),
  .last_of_run  (last_of_run)
);
